// ----- src/lac_pkg.sv -----
// Shared types for the layer alpha compositor: sequencer states, divider selects, control groups.
package lac_pkg;

  // Data channel widths fixed by the pixel format
  localparam int unsigned ChanW  = 8;
  localparam int unsigned TdataW = 4 * ChanW;

  typedef enum logic [3:0] {
    S_IDLE,
    S_AF,
    S_WGT,
    S_ACC,
    S_CHK,
    S_B_GO,
    S_B_WAIT,
    S_G_GO,
    S_G_WAIT,
    S_R_GO,
    S_R_WAIT,
    S_EMIT
  } lac_state_e;

  typedef enum logic [1:0] {
    DIV_BLUE,
    DIV_GREEN,
    DIV_RED
  } lac_div_sel_e;

  typedef struct packed {
    logic         load;       // capture the incoming layer word
    logic         af_load;    // store the layer opacity fraction
    logic         div_start;  // launch the serial divider
    logic         div_take;   // store the divider quotient
    lac_div_sel_e div_sel;    // operand and destination of the divide
    logic         mul_w;      // form the layer weight
    logic         acc;        // fold the weight into the running sums
    logic         out_load;   // move the finished pixel into the output register
  } lac_cmd_t;

  typedef struct packed {
    logic div_done;
    logic last;
    logic alpha_zero;
    logic out_free;
  } lac_status_t;

endpackage

// ----- src/lac_div.sv -----
// Restoring divider, one quotient bit per cycle.
module lac_div import lac_pkg::*; #(
  parameter int unsigned DW = 25,
  parameter int unsigned VW = 17
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic [DW-1:0] quotient_o,
  output logic          done_o
);

  localparam int unsigned CntW = (DW > 1) ? $clog2(DW) : 1;
  localparam logic [CntW-1:0] CntLast = CntW'(DW - 1);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DW-1:0]   quo_q, quo_d;
  logic [VW:0]     rem_q, rem_d;
  logic [VW-1:0]   dvs_q, dvs_d;
  logic [VW:0]     rem_sh;
  logic            fits;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    rem_sh = {rem_q[VW-1:0], quo_q[DW-1]};
    fits   = rem_sh >= {1'b0, dvs_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
      quo_d = {quo_q[DW-2:0], fits};
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntLast) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

// ----- src/lac_dp.sv -----
// Compositor datapath: layer registers, weight multiply, running sums, divider and output register.
module lac_dp import lac_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lac_cmd_t          cmd_i,
  output lac_status_t       sts_o,
  input  logic [TdataW-1:0] in_data_i,
  input  logic              in_last_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [TdataW-1:0] out_data_o
);

  localparam int unsigned VW = FRAC_BITS + 1;         // fractions up to ONE
  localparam int unsigned SW = FRAC_BITS + ChanW + 1; // colour sums
  localparam int unsigned PW = 2 * VW;                // weight product
  localparam logic [VW-1:0] One    = VW'(1) << FRAC_BITS;
  localparam int unsigned   AfQuo  = (1 << FRAC_BITS) / 255;
  localparam int unsigned   AfRem  = (1 << FRAC_BITS) % 255;

  logic [ChanW-1:0] blue_q, green_q, red_q, alpha_q;
  logic             last_q;
  logic [VW-1:0]    af_q, w_q;
  logic [VW-1:0]    rt_q, asum_q;
  logic [SW-1:0]    bsum_q, gsum_q, rsum_q;
  logic [ChanW-1:0] qb_q, qg_q, qr_q;
  logic             ovld_q;
  logic [TdataW-1:0] odata_q;

  logic [SW-1:0]    dividend;
  logic [VW-1:0]    divisor;
  logic [SW-1:0]    quotient;
  logic             div_done;
  logic [PW-1:0]    w_prod;
  logic [VW+ChanW-1:0] a255;
  logic [ChanW-1:0] oalpha;
  logic [15:0]      af_lo;
  logic [15:0]      af_fix;
  logic [VW-1:0]    af_calc;

  always_comb begin
    dividend = '0;
    case (cmd_i.div_sel)
      DIV_BLUE:  dividend = bsum_q;
      DIV_GREEN: dividend = gsum_q;
      DIV_RED:   dividend = rsum_q;
      default:   dividend = '0;
    endcase
  end

  assign divisor = asum_q;

  lac_div #(
    .DW (SW),
    .VW (VW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .quotient_o (quotient),
    .done_o     (div_done)
  );

  // Opacity fraction: split ONE into a multiple of 255 and a small remainder;
  // the remainder term divides by 255 exactly with a shift-and-add
  assign af_lo   = 16'(alpha_q) * 16'(AfRem);
  assign af_fix  = (af_lo + 16'd1 + (af_lo >> 8)) >> 8;
  assign af_calc = VW'(alpha_q) * VW'(AfQuo) + VW'(af_fix);

  assign w_prod = PW'(rt_q) * PW'(af_q);
  assign a255   = {asum_q, {ChanW{1'b0}}} - (VW + ChanW)'(asum_q);
  assign oalpha = a255[FRAC_BITS +: ChanW];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      blue_q  <= in_data_i[0*ChanW +: ChanW];
      green_q <= in_data_i[1*ChanW +: ChanW];
      red_q   <= in_data_i[2*ChanW +: ChanW];
      alpha_q <= in_data_i[3*ChanW +: ChanW];
      last_q  <= in_last_i;
    end
    if (cmd_i.af_load) begin
      af_q <= af_calc;
    end
    if (cmd_i.div_take) begin
      case (cmd_i.div_sel)
        DIV_BLUE:  qb_q <= quotient[ChanW-1:0];
        DIV_GREEN: qg_q <= quotient[ChanW-1:0];
        DIV_RED:   qr_q <= quotient[ChanW-1:0];
        default:   qb_q <= qb_q;
      endcase
    end
    if (cmd_i.mul_w) begin
      w_q <= w_prod[FRAC_BITS +: VW];
    end
    if (cmd_i.out_load) begin
      if (asum_q == '0) begin
        odata_q <= {{ChanW{1'b0}}, {(3 * ChanW){1'b1}}};
      end else begin
        odata_q <= {oalpha, qr_q, qg_q, qb_q};
      end
    end
  end

  // Running state per pixel position; restart once the pixel is emitted
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rt_q   <= One;
      asum_q <= '0;
      bsum_q <= '0;
      gsum_q <= '0;
      rsum_q <= '0;
      ovld_q <= 1'b0;
    end else begin
      if (cmd_i.out_load) begin
        rt_q   <= One;
        asum_q <= '0;
        bsum_q <= '0;
        gsum_q <= '0;
        rsum_q <= '0;
      end else if (cmd_i.acc) begin
        rt_q   <= rt_q - w_q;
        asum_q <= asum_q + w_q;
        bsum_q <= bsum_q + SW'(w_q * (VW + ChanW)'(blue_q));
        gsum_q <= gsum_q + SW'(w_q * (VW + ChanW)'(green_q));
        rsum_q <= rsum_q + SW'(w_q * (VW + ChanW)'(red_q));
      end
      if (cmd_i.out_load) begin
        ovld_q <= 1'b1;
      end else if (out_ready_i) begin
        ovld_q <= 1'b0;
      end
    end
  end

  assign sts_o.div_done   = div_done;
  assign sts_o.last       = last_q;
  assign sts_o.alpha_zero = (asum_q == '0);
  assign sts_o.out_free   = !ovld_q || out_ready_i;

  assign out_valid_o = ovld_q;
  assign out_data_o  = odata_q;

endmodule

// ----- src/lac_ctrl.sv -----
// Compositor sequencer: opacity, weight, accumulate per layer; divides after the last.
module lac_ctrl import lac_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  lac_status_t sts_i,
  output lac_cmd_t    cmd_o
);

  lac_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.div_sel = DIV_BLUE;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_AF;
        end
      end
      S_AF: begin
        cmd_o.af_load = 1'b1;
        state_d       = S_WGT;
      end
      S_WGT: begin
        cmd_o.mul_w = 1'b1;
        state_d     = S_ACC;
      end
      S_ACC: begin
        cmd_o.acc = 1'b1;
        state_d   = sts_i.last ? S_CHK : S_IDLE;
      end
      // a fully transparent stack skips the divides
      S_CHK: state_d = sts_i.alpha_zero ? S_EMIT : S_B_GO;
      S_B_GO: begin
        cmd_o.div_sel   = DIV_BLUE;
        cmd_o.div_start = 1'b1;
        state_d         = S_B_WAIT;
      end
      S_B_WAIT: begin
        cmd_o.div_sel = DIV_BLUE;
        if (sts_i.div_done) begin
          cmd_o.div_take = 1'b1;
          state_d        = S_G_GO;
        end
      end
      S_G_GO: begin
        cmd_o.div_sel   = DIV_GREEN;
        cmd_o.div_start = 1'b1;
        state_d         = S_G_WAIT;
      end
      S_G_WAIT: begin
        cmd_o.div_sel = DIV_GREEN;
        if (sts_i.div_done) begin
          cmd_o.div_take = 1'b1;
          state_d        = S_R_GO;
        end
      end
      S_R_GO: begin
        cmd_o.div_sel   = DIV_RED;
        cmd_o.div_start = 1'b1;
        state_d         = S_R_WAIT;
      end
      S_R_WAIT: begin
        cmd_o.div_sel = DIV_RED;
        if (sts_i.div_done) begin
          cmd_o.div_take = 1'b1;
          state_d        = S_EMIT;
        end
      end
      S_EMIT: begin
        // hold until the output register can take the pixel
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ----- src/layer_alpha_compositor.sv -----
// Top level of the front-to-back alpha-over compositor.
//
//  Channel  Dir  Handshake              Word contents
//  s_axis   in   s_axis_tvalid/tready   tdata: blue, green, red, alpha; tlast: last layer
//  m_axis   out  m_axis_tvalid/tready   tdata: blue, green, red, alpha of the composite
//
// Each layer word is stepped through accept, opacity fraction, weight multiply and accumulate.
// The last layer adds three bit-serial colour divides (FRAC_BITS+9 quotient bits each);
// a fully transparent stack skips the divides.
// Reset clears the sequencer and the running sums; no clearing pass.
// A result waiting on m_axis stalls only the final load of the next pixel.
module layer_alpha_compositor import lac_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [TdataW-1:0] s_axis_tdata,  // blue[7:0], green, red, alpha[31:24]
  input  logic              s_axis_tlast,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [TdataW-1:0] m_axis_tdata   // blue[7:0], green, red, alpha[31:24]
);

  lac_cmd_t    cmd;
  lac_status_t sts;

  lac_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lac_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule
